>>> design/swo_pkg.sv
// shared types, constants and helper functions for the swerve odometry unit
package swo_pkg;

   localparam int NUM_MOD      = 3;
   localparam int SPD_W        = 16;
   localparam int ANG_W        = 16;
   localparam int CW           = 20;
   localparam int ZW           = 17;
   localparam int MV_W         = 26;
   localparam int VEL_W        = 24;
   localparam int POS_W        = 32;
   localparam int HDG_W        = 16;
   localparam int CFG_W        = 16;
   localparam int STEP_W       = 4;
   localparam int CORDIC_STEPS = 14;

   localparam logic signed [CW-1:0] CORDIC_GAIN = 20'sd39797;
   localparam logic signed [ZW-1:0] PI_Q13      = 17'sd25736;
   localparam logic signed [ZW-1:0] HALF_PI_Q13 = 17'sd12868;

   localparam logic [CFG_W-1:0] RADIUS_RESET = 16'd3015;
   localparam logic [CFG_W-1:0] STEP_RESET   = 16'd3277;

   localparam logic signed [47:0] THIRD_Q16  = 48'sd21845;
   localparam logic signed [47:0] W_X_SIDE   = 48'sd75699;
   localparam logic signed [47:0] W_Y_SIDE   = 48'sd31927;
   localparam logic signed [47:0] W_Y_REAR   = 48'sd105703;
   localparam logic signed [47:0] HALF_Q16   = 48'sd32768;

   typedef enum logic [1:0] {
      ACT_SAMPLE = 2'd0,
      ACT_RESET  = 2'd1,
      ACT_SET    = 2'd2,
      ACT_NONE   = 2'd3
   } swo_action_type;

   typedef enum logic {
      CSR_RADIUS = 1'b0,
      CSR_STEP   = 1'b1
   } swo_csr_type;

   typedef struct packed {
      logic sum_en;
      logic scale_en;
      logic sat_en;
      logic delta_en;
   } swo_mctl_type;

   function automatic logic signed [ZW-1:0] atan_q13(input logic [STEP_W-1:0] idx);
      logic signed [ZW-1:0] r;
      case (idx)
         4'd0:    r = 17'sd6434;
         4'd1:    r = 17'sd3798;
         4'd2:    r = 17'sd2007;
         4'd3:    r = 17'sd1019;
         4'd4:    r = 17'sd511;
         4'd5:    r = 17'sd256;
         4'd6:    r = 17'sd128;
         4'd7:    r = 17'sd64;
         4'd8:    r = 17'sd32;
         4'd9:    r = 17'sd16;
         4'd10:   r = 17'sd8;
         4'd11:   r = 17'sd4;
         4'd12:   r = 17'sd2;
         4'd13:   r = 17'sd1;
         default: r = 17'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [47:0] v);
      logic signed [VEL_W-1:0] r;
      if (v > 48'sd8388607)
         r = 24'sh7FFFFF;
      else if (v < -48'sd8388608)
         r = 24'sh800000;
      else
         r = v[VEL_W-1:0];
      return r;
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [33:0] v);
      logic signed [POS_W-1:0] r;
      if (v > 34'sd2147483647)
         r = 32'sh7FFFFFFF;
      else if (v < -34'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[POS_W-1:0];
      return r;
   endfunction

endpackage

>>> design/three_wheel_swerve_odometry_unit.sv
// top level of the three-module swerve odometry unit
// a wheel sample runs 14 cordic rotations and the multiply steps mul1 and mul2 in the
// lanes, then the done check, merge steps sum, scale, sat and delta, pose update, output
// reset-pose, set-pose and unused beats go from accept straight to the output state
// one beat is in work at a time: a new beat is taken once the last result is registered
// synchronous reset clears the pose to zero and loads the default registers
module three_wheel_swerve_odometry_unit import swo_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // speed a, b, c, steer angle a, b, c, new x, new y, new heading
   input  logic [175:0] req_tdata,
   // action
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vel x, vel y, turn rate, pos x, pos y, heading
   output logic [151:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_LANE, S_SUM, S_SCALE, S_SAT, S_DELTA, S_ACC, S_OUT
   } top_state_type;

   top_state_type           state_ff;
   logic [CFG_W-1:0]        radius_ff, tstep_ff;
   logic signed [POS_W-1:0] acc_x_ff, acc_y_ff;
   logic signed [HDG_W-1:0] hdg_ff;
   logic signed [VEL_W-1:0] pvx_ff, pvy_ff, pwz_ff;
   logic                    rsp_valid_ff;
   logic [151:0]            rsp_data_ff;
   logic                    accept, start;
   logic [NUM_MOD-1:0]      lane_done;
   logic signed [MV_W-1:0]  mod_x [NUM_MOD];
   logic signed [MV_W-1:0]  mod_y [NUM_MOD];
   swo_mctl_type            mctl;
   logic signed [VEL_W-1:0] m_vx, m_vy, m_wz;
   logic signed [MV_W-1:0]  m_dx, m_dy;
   logic signed [POS_W-1:0] acc_x_in, acc_y_in;
   logic                    out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign start      = accept && (swo_action_type'(req_tuser) == ACT_SAMPLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   genvar g;
   generate
      for (g = 0; g < NUM_MOD; g++) begin : g_lane
         swo_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .start  (start),
            .radius (radius_ff),
            .speed  (req_tdata[g*SPD_W +: SPD_W]),
            .angle  (req_tdata[NUM_MOD*SPD_W + g*ANG_W +: ANG_W]),
            .done   (lane_done[g]),
            .vel_x  (mod_x[g]),
            .vel_y  (mod_y[g])
         );
      end
   endgenerate

   always_comb begin
      mctl.sum_en   = (state_ff == S_SUM);
      mctl.scale_en = (state_ff == S_SCALE);
      mctl.sat_en   = (state_ff == S_SAT);
      mctl.delta_en = (state_ff == S_DELTA);
      acc_x_in      = sat_pos(34'(acc_x_ff) + 34'(m_dx));
      acc_y_in      = sat_pos(34'(acc_y_ff) + 34'(m_dy));
   end

   swo_merge u_merge (
      .clock     (clock),
      .ctl       (mctl),
      .time_step (tstep_ff),
      .mod_x     (mod_x),
      .mod_y     (mod_y),
      .vel_x     (m_vx),
      .vel_y     (m_vy),
      .turn_rate (m_wz),
      .delta_x   (m_dx),
      .delta_y   (m_dy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         radius_ff    <= RADIUS_RESET;
         tstep_ff     <= STEP_RESET;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         hdg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (swo_csr_type'(csr_index))
               CSR_RADIUS: radius_ff <= csr_wdata;
               CSR_STEP:   tstep_ff  <= csr_wdata;
               default:    ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != S_OUT))
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  pvx_ff <= '0;
                  pvy_ff <= '0;
                  pwz_ff <= '0;
                  case (swo_action_type'(req_tuser))
                     ACT_SAMPLE: state_ff <= S_LANE;
                     ACT_RESET: begin
                        acc_x_ff <= '0;
                        acc_y_ff <= '0;
                        hdg_ff   <= '0;
                        state_ff <= S_OUT;
                     end
                     ACT_SET: begin
                        acc_x_ff <= req_tdata[127:96];
                        acc_y_ff <= req_tdata[159:128];
                        hdg_ff   <= req_tdata[175:160];
                        state_ff <= S_OUT;
                     end
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_LANE:  if (&lane_done) state_ff <= S_SUM;
            S_SUM:   state_ff <= S_SCALE;
            S_SCALE: state_ff <= S_SAT;
            S_SAT:   state_ff <= S_DELTA;
            S_DELTA: state_ff <= S_ACC;
            S_ACC: begin
               acc_x_ff <= acc_x_in;
               acc_y_ff <= acc_y_in;
               pvx_ff   <= m_vx;
               pvy_ff   <= m_vy;
               pwz_ff   <= m_wz;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {hdg_ff, acc_y_ff, acc_x_ff, pwz_ff, pvy_ff, pvx_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> design/swo_lane.sv
// one swerve module lane: iterative cordic sine/cosine and wheel velocity scaling
module swo_lane import swo_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [CFG_W-1:0]        radius,
   input  logic signed [SPD_W-1:0] speed,
   input  logic signed [ANG_W-1:0] angle,
   output logic                    done,
   output logic signed [MV_W-1:0]  vel_x,
   output logic signed [MV_W-1:0]  vel_y
);

   typedef enum logic [1:0] {L_IDLE, L_ROT, L_MUL1, L_MUL2} lane_state_type;

   lane_state_type          state_ff;
   logic [STEP_W-1:0]       step_ff;
   logic signed [CW-1:0]    x_ff, y_ff, x_in, y_in;
   logic signed [ZW-1:0]    z_ff, z_in, z_fold;
   logic                    neg_ff, neg_fold;
   logic signed [SPD_W-1:0] spd_ff;
   logic signed [35:0]      ps_ff, pc_ff, ps_in, pc_in;
   logic signed [52:0]      ls, lc;
   logic signed [MV_W-1:0]  vx_ff, vy_ff, vx_in, vy_in;
   logic                    done_ff;
   logic signed [CW-1:0]    xs, ys, sn, cs;
   logic signed [52:0]      rad_s;

   always_comb begin
      z_fold   = ZW'(angle);
      neg_fold = 1'b0;
      if (z_fold > HALF_PI_Q13) begin
         z_fold   = z_fold - PI_Q13;
         neg_fold = 1'b1;
      end else if (z_fold < -HALF_PI_Q13) begin
         z_fold   = z_fold + PI_Q13;
         neg_fold = 1'b1;
      end
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      if (z_ff >= 0) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - atan_q13(step_ff);
      end else begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + atan_q13(step_ff);
      end
      sn    = neg_ff ? -y_ff : y_ff;
      cs    = neg_ff ? -x_ff : x_ff;
      ps_in = 36'(spd_ff) * 36'(sn);
      pc_in = 36'(spd_ff) * 36'(cs);
      rad_s = 53'($signed({1'b0, radius}));
      ls    = (53'(ps_ff) * rad_s + 53'sd8388608) >>> 24;
      lc    = (53'(pc_ff) * rad_s + 53'sd8388608) >>> 24;
      vx_in = -ls[MV_W-1:0];
      vy_in = lc[MV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else if (start) begin
         state_ff <= L_ROT;
         done_ff  <= 1'b0;
         step_ff  <= '0;
         x_ff     <= CORDIC_GAIN;
         y_ff     <= '0;
         z_ff     <= z_fold;
         neg_ff   <= neg_fold;
         spd_ff   <= speed;
      end else begin
         case (state_ff)
            L_ROT: begin
               x_ff    <= x_in;
               y_ff    <= y_in;
               z_ff    <= z_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(CORDIC_STEPS - 1))
                  state_ff <= L_MUL1;
            end
            L_MUL1: begin
               ps_ff    <= ps_in;
               pc_ff    <= pc_in;
               state_ff <= L_MUL2;
            end
            L_MUL2: begin
               vx_ff    <= vx_in;
               vy_ff    <= vy_in;
               done_ff  <= 1'b1;
               state_ff <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign done  = done_ff;
   assign vel_x = vx_ff;
   assign vel_y = vy_ff;

endmodule

>>> design/swo_merge.sv
// merges lane velocities into body velocity, turn rate and position deltas
module swo_merge import swo_pkg::*; (
   input  logic                   clock,
   input  swo_mctl_type           ctl,
   input  logic [CFG_W-1:0]       time_step,
   input  logic signed [MV_W-1:0] mod_x [NUM_MOD],
   input  logic signed [MV_W-1:0] mod_y [NUM_MOD],
   output logic signed [VEL_W-1:0] vel_x,
   output logic signed [VEL_W-1:0] vel_y,
   output logic signed [VEL_W-1:0] turn_rate,
   output logic signed [MV_W-1:0]  delta_x,
   output logic signed [MV_W-1:0]  delta_y
);

   logic signed [27:0]      sx_ff, sy_ff, tx_ff, tf_ff, tr_ff;
   logic signed [47:0]      mx_ff, my_ff, wt_ff;
   logic signed [VEL_W-1:0] vx_ff, vy_ff, wz_ff;
   logic signed [MV_W-1:0]  dx_ff, dy_ff;
   logic signed [47:0]      ts_s, dx_p, dy_p;

   always_comb begin
      ts_s = 48'($signed({1'b0, time_step}));
      dx_p = (48'(vx_ff) * ts_s + HALF_Q16) >>> 16;
      dy_p = (48'(vy_ff) * ts_s + HALF_Q16) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_en) begin
         sx_ff <= 28'(mod_x[0]) + 28'(mod_x[1]) + 28'(mod_x[2]);
         sy_ff <= 28'(mod_y[0]) + 28'(mod_y[1]) + 28'(mod_y[2]);
         tx_ff <= 28'(mod_x[1]) - 28'(mod_x[0]);
         tf_ff <= 28'(mod_y[0]) + 28'(mod_y[1]);
         tr_ff <= 28'(mod_y[2]);
      end
      if (ctl.scale_en) begin
         mx_ff <= 48'(sx_ff) * THIRD_Q16;
         my_ff <= 48'(sy_ff) * THIRD_Q16;
         wt_ff <= 48'(tx_ff) * W_X_SIDE - 48'(tf_ff) * W_Y_SIDE + 48'(tr_ff) * W_Y_REAR;
      end
      if (ctl.sat_en) begin
         vx_ff <= sat_vel((mx_ff + HALF_Q16) >>> 16);
         vy_ff <= sat_vel((my_ff + HALF_Q16) >>> 16);
         wz_ff <= sat_vel((wt_ff + HALF_Q16) >>> 16);
      end
      if (ctl.delta_en) begin
         dx_ff <= dx_p[MV_W-1:0];
         dy_ff <= dy_p[MV_W-1:0];
      end
   end

   assign vel_x     = vx_ff;
   assign vel_y     = vy_ff;
   assign turn_rate = wz_ff;
   assign delta_x   = dx_ff;
   assign delta_y   = dy_ff;

endmodule

>>> design/swo_checker.sv
// port-level checks for the swerve odometry unit and their binding
module swo_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [151:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat taken while one is in work");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind three_wheel_swerve_odometry_unit swo_checker u_swo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/swo_checker.sv
// checker for the swerve odometry unit: predicts each result beat and compares it
module swo_scoreboard import swo_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [175:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [151:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata,
   output int           fail_count,
   output int           pending_count,
   output int           sample_count
);

   typedef struct packed {
      logic signed [15:0] hdg;
      logic signed [31:0] py;
      logic signed [31:0] px;
      logic signed [23:0] wz;
      logic signed [23:0] vy;
      logic signed [23:0] vx;
   } odo_result_t;

   odo_result_t pose_queue[$];
   longint odo_x, odo_y, odo_hdg, radius_q16, step_q16;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_up(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) << (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   task automatic rotate_angle(input longint ang, output longint sn, output longint cs);
      longint x, y, z, nx;
      longint atans[14];
      bit flip;
      atans = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
      x = 39797; y = 0; z = ang; flip = 0;
      if (z > 12868) begin
         z -= 25736; flip = 1;
      end else if (z < -12868) begin
         z += 25736; flip = 1;
      end
      for (int i = 0; i < 14; i++) begin
         if (z >= 0) begin
            nx = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= atans[i];
         end else begin
            nx = x + floor_shift(y, i); y = y - floor_shift(x, i); z += atans[i];
         end
         x = nx;
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endtask

   task automatic predict_pose(input logic [175:0] d, input logic [1:0] act);
      odo_result_t r;
      longint sx, sy, st, spd, sn, cs, mx, my, vx, vy, wz;
      longint wxs[3], wys[3];
      wxs = '{-75699, 75699, 0};
      wys = '{-31927, -31927, 105703};
      vx = 0; vy = 0; wz = 0; sx = 0; sy = 0; st = 0;
      case (swo_action_type'(act))
         ACT_SAMPLE: begin
            for (int k = 0; k < 3; k++) begin
               spd = longint'($signed(d[16*k +: 16]));
               rotate_angle(longint'($signed(d[48 + 16*k +: 16])), sn, cs);
               mx = -round_up(spd * sn * radius_q16, 24);
               my = round_up(spd * cs * radius_q16, 24);
               sx += mx; sy += my; st += wxs[k] * mx + wys[k] * my;
            end
            vx = clamp(round_up(sx * 21845, 16), 24);
            vy = clamp(round_up(sy * 21845, 16), 24);
            wz = clamp(round_up(st, 16), 24);
            odo_x = clamp(odo_x + round_up(vx * step_q16, 16), 32);
            odo_y = clamp(odo_y + round_up(vy * step_q16, 16), 32);
         end
         ACT_RESET: begin
            odo_x = 0; odo_y = 0; odo_hdg = 0;
         end
         ACT_SET: begin
            odo_x = longint'($signed(d[96 +: 32]));
            odo_y = longint'($signed(d[128 +: 32]));
            odo_hdg = longint'($signed(d[160 +: 16]));
         end
         default: ;
      endcase
      r.vx = vx[23:0]; r.vy = vy[23:0]; r.wz = wz[23:0];
      r.px = odo_x[31:0]; r.py = odo_y[31:0]; r.hdg = odo_hdg[15:0];
      pose_queue.push_back(r);
   endtask

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      odo_result_t want, got;
      if (reset) begin
         odo_x <= 0; odo_y <= 0; odo_hdg <= 0;
         radius_q16 <= RADIUS_RESET; step_q16 <= STEP_RESET;
         pose_queue.delete();
         fail_count <= 0; sample_count <= 0;
      end else begin
         if (csr_we) begin
            if (swo_csr_type'(csr_index) == CSR_RADIUS) radius_q16 = csr_wdata;
            else step_q16 = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pose_queue.size() == 0) begin
               $error("result beat with no expectation waiting");
               fail_count++;
            end else begin
               want = pose_queue.pop_front();
               compare_field("vel_x", want.vx, got.vx);
               compare_field("vel_y", want.vy, got.vy);
               compare_field("turn_rate", want.wz, got.wz);
               compare_field("pos_x", want.px, got.px);
               compare_field("pos_y", want.py, got.py);
               compare_field("heading", want.hdg, got.hdg);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_pose(req_tdata, req_tuser);
            if (req_tuser == ACT_SAMPLE) sample_count++;
         end
      end
      pending_count = pose_queue.size();
   end

endmodule

>>> tb/tb_three_wheel_swerve_odometry_unit.sv
// testbench top for the swerve odometry unit: stimulus, stalls and verdict
module tb_three_wheel_swerve_odometry_unit;
   import swo_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [175:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [151:0] rsp_tdata;
   logic         csr_we;
   logic         csr_index;
   logic [15:0]  csr_wdata;
   int           fail_count;
   int           pending_count;
   int           sample_count;
   int           total_beats;
   bit           hold_off;

   three_wheel_swerve_odometry_unit i_dut (.*);
   swo_scoreboard i_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("DONE: errors detected");
      $finish;
   end

   // receiver stalls, with one long hold-off requested by the sender side
   initial begin
      int gap;
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_tready <= 0;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   function automatic logic [15:0] edgy16();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [175:0] random_payload(bit full_speed);
      logic [175:0] d;
      for (int k = 0; k < 11; k++) d[16*k +: 16] = 16'($urandom());
      if (!full_speed)
         for (int k = 0; k < 3; k++)
            d[16*k +: 16] = $signed(d[16*k +: 16]) >>> $urandom_range(0, 10);
      if ($urandom_range(0, 7) == 0)
         for (int k = 0; k < 6; k++) d[16*k +: 16] = edgy16();
      return d;
   endfunction

   task automatic send_beat(logic [1:0] act, logic [175:0] d, int gap);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= act;
      req_tdata  <= d;
      total_beats++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_and_write(logic idx, logic [15:0] val);
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
   endtask

   initial begin
      logic [175:0] d;
      logic [1:0]   act;
      logic [15:0]  radii[5];
      logic [15:0]  steps[5];
      radii = '{16'd0, 16'hFFFF, 16'd3015, 16'd40000, 16'd777};
      steps = '{16'hFFFF, 16'd0, 16'd3277, 16'd12345, 16'd65000};
      req_tvalid = 0; req_tdata = '0; req_tuser = ACT_SAMPLE;
      csr_we = 0; csr_index = CSR_RADIUS; csr_wdata = '0;
      hold_off = 0; total_beats = 0;
      reset = 1;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, each action, angle folds, saturation
      send_beat(ACT_SAMPLE, '0, 0);
      send_beat(ACT_SAMPLE, {16'h7FFF, 32'h7FFFFFFF, 32'h80000000,
                             16'h8000, 16'h7FFF, 16'h0000,
                             16'h7FFF, 16'h8000, 16'h7FFF}, 0);
      send_beat(ACT_SAMPLE, {80'h0, 16'd12868, 16'd12869, 16'hCDBC,
                             16'h7FFF, 16'h7FFF, 16'h7FFF}, 1);
      send_beat(ACT_SAMPLE, {80'h0, 16'hCDBB, 16'h8000, 16'd25736,
                             16'h8000, 16'h8000, 16'h8000}, 0);
      send_beat(ACT_SET, {16'h7FFF, 32'h7FFFFFF0, 32'h7FFFFFF0, 96'h0}, 2);
      for (int i = 0; i < 4; i++)
         send_beat(ACT_SAMPLE, {80'h0, 48'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 0);
      send_beat(ACT_SET, {16'h8000, 32'h80000010, 32'h80000010, 96'h0}, 0);
      for (int i = 0; i < 4; i++)
         send_beat(ACT_SAMPLE, {80'h0, 48'h0, 16'h8000, 16'h8000, 16'h8000}, 0);
      send_beat(ACT_NONE, {16'hFFFF, 160'h0}, 3);
      send_beat(ACT_RESET, '1, 0);
      send_beat(ACT_NONE, '1, 0);
      send_beat(ACT_SET, '1, 0);
      send_beat(ACT_SAMPLE, '1, 0);
      drain_and_write(CSR_RADIUS, 16'hFFFF);
      drain_and_write(CSR_STEP, 16'hFFFF);
      send_beat(ACT_SAMPLE, {80'h0, 48'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 0);
      send_beat(ACT_SAMPLE, {80'h0, 16'h1000, 16'h1000, 16'h1000,
                             16'h8000, 16'h8000, 16'h8000}, 0);

      // random phases over several register settings
      for (int ph = 0; ph < 5; ph++) begin
         drain_and_write(CSR_RADIUS, radii[ph]);
         drain_and_write(CSR_STEP, steps[ph]);
         for (int i = 0; i < 365; i++) begin
            if (ph == 1 && i == 40) hold_off = 1;
            if (ph == 2 && i == 100) begin
               req_tvalid <= 0;
               @(posedge clock);
               while (pending_count != 0) @(posedge clock);
            end
            case ($urandom_range(0, 19))
               0:       act = ACT_RESET;
               1, 2:    act = ACT_SET;
               3:       act = ACT_NONE;
               default: act = ACT_SAMPLE;
            endcase
            d = random_payload(1'($urandom_range(0, 1)));
            send_beat(act, d, (hold_off || $urandom_range(0, 3) == 0) ? 0 :
                      $urandom_range(0, 5));
         end
      end

      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d beats, %0d wheel samples, five radius and step settings",
               total_beats, sample_count);
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
